[rtl/two_level_page_table_walker_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the two-level page table walker
// Each check is active in simulation and empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_TOP_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TLPW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlpw check failed");
`define TLPW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlpw check failed");
`else
`define TLPW_ASSERT_NOW(lbl, ante, cons)
`define TLPW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/tlpw_pkg.sv]
// ----------------------------------------------------------------------------
// Two-level page table walker package
// Shared widths, memory layout and operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tlpw_pkg;
  localparam int DIR_AW    = 10;
  localparam int SLOT_W    = 4;
  localparam int PTE_AW    = 10;
  localparam int TBL_AW    = SLOT_W + PTE_AW;
  localparam int CNT_W     = PTE_AW + 1;
  localparam int DMEM_W    = 32 + SLOT_W + CNT_W;
  localparam int PAGES_W   = 21;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(1 << PTE_AW);

  typedef enum logic [1:0] {
    OP_WDIR  = 2'd0,
    OP_WTBL  = 2'd1,
    OP_TRANS = 2'd2,
    OP_FIND  = 2'd3
  } op_t;
endpackage

[rtl/two_level_page_table_walker_top.sv]
// ----------------------------------------------------------------------------
// Two-level page table walker
// Directory, table and used-count memories with translate and free search.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every word of the table
// memory (and the directory memory alongside) and takes no word until it ends.
// A directory or table write passes S_WR and S_RESP, a translate S_TDIR, then
// S_TPTE for a table entry, and S_RESP; each waits on the registered read of
// the synchronous memories before the read-modify-write or lookup. A free search
// visits directory entries in S_FCNT and scans the pages of each partly used
// entry in S_FPTE, reading the table memory for each page it scans.
// Any operation takes longer while the previous result word still waits at
// the output.
`timescale 1ns / 1ps
`include "two_level_page_table_walker_top_defines.svh"
module two_level_page_table_walker_top
  import tlpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [9:0]  in_dir_index,
  input  logic [9:0]  in_table_index,
  input  logic [31:0] in_entry_value,
  input  logic [3:0]  in_table_slot,
  input  logic [31:0] in_address,
  input  logic [31:0] in_size_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_mapped,
  output logic [39:0] out_phys_addr,
  output logic        out_found,
  output logic [31:0] out_free_addr
);
  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_WR, S_TDIR, S_TPTE, S_FCNT, S_FPTE, S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic [TBL_AW-1:0] clr_r, clr_nxt;
  op_t op_r, op_nxt;
  logic [DIR_AW-1:0] di_r, di_nxt;
  logic [PTE_AW-1:0] ti_r, ti_nxt;
  logic [31:0] val_r, val_nxt, va_r, va_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt, fslot_r, fslot_nxt;
  logic [PAGES_W-1:0] pages_r, pages_nxt, avail_r, avail_nxt;
  logic [DIR_AW:0] pde_r, pde_nxt;
  logic [PTE_AW-1:0] pte_r, pte_nxt;
  logic have_r, have_nxt;
  logic [31:0] ret_r, ret_nxt;
  logic res_mapped_r, res_mapped_nxt, res_found_r, res_found_nxt;
  logic [39:0] res_pa_r, res_pa_nxt;
  logic [31:0] res_free_r, res_free_nxt;
  logic out_valid_r, out_valid_nxt, out_mapped_r, out_mapped_nxt;
  logic out_found_r, out_found_nxt;
  logic [39:0] out_pa_r, out_pa_nxt;
  logic [31:0] out_free_r, out_free_nxt;

  logic dmem_we, tmem_we;
  logic [DIR_AW-1:0] dmem_waddr, dmem_raddr;
  logic [DMEM_W-1:0] dmem_wdata, dmem_rdata;
  logic [TBL_AW-1:0] tmem_waddr, tmem_raddr;
  logic [31:0] tmem_wdata, tmem_rdata;

  logic [20:0] start;
  logic [32:0] pages_wide;
  logic [31:0] dent, tent;
  logic [SLOT_W-1:0] dslot;
  logic [CNT_W-1:0] dcnt, cnt_new;

  tlpw_ram #(.WIDTH(DMEM_W), .DEPTH(1 << DIR_AW)) u_dir_ram (
    .clk(clk), .we(dmem_we), .waddr(dmem_waddr), .wdata(dmem_wdata),
    .raddr(dmem_raddr), .rdata(dmem_rdata)
  );

  tlpw_ram #(.WIDTH(32), .DEPTH(1 << TBL_AW)) u_tbl_ram (
    .clk(clk), .we(tmem_we), .waddr(tmem_waddr), .wdata(tmem_wdata),
    .raddr(tmem_raddr), .rdata(tmem_rdata)
  );

  assign dent  = dmem_rdata[DMEM_W-1 -: 32];
  assign dslot = dmem_rdata[CNT_W +: SLOT_W];
  assign dcnt  = dmem_rdata[CNT_W-1:0];
  assign tent  = tmem_rdata;
  assign start = {1'b0, in_address[31:12]} + {20'd0, |in_address[11:0]};
  assign pages_wide = ({1'b0, in_size_bytes} + 33'hFFF) >> 12;

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_mapped    = out_mapped_r;
  assign out_phys_addr = out_pa_r;
  assign out_found     = out_found_r;
  assign out_free_addr = out_free_r;

  always_comb begin
    state_nxt = state_r;  clr_nxt = clr_r;  op_nxt = op_r;  di_nxt = di_r;
    ti_nxt = ti_r;  val_nxt = val_r;  va_nxt = va_r;  slot_nxt = slot_r;
    fslot_nxt = fslot_r;  pages_nxt = pages_r;  avail_nxt = avail_r;
    pde_nxt = pde_r;  pte_nxt = pte_r;  have_nxt = have_r;  ret_nxt = ret_r;
    res_mapped_nxt = res_mapped_r;  res_found_nxt = res_found_r;
    res_pa_nxt = res_pa_r;  res_free_nxt = res_free_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_mapped_nxt = out_mapped_r;  out_found_nxt = out_found_r;
    out_pa_nxt = out_pa_r;  out_free_nxt = out_free_r;
    dmem_we = 1'b0;  dmem_waddr = di_r;  dmem_wdata = '0;  dmem_raddr = di_r;
    tmem_we = 1'b0;  tmem_waddr = {slot_r, ti_r};  tmem_wdata = val_r;
    tmem_raddr = {slot_r, ti_r};
    cnt_new = dcnt;

    case (state_r)
      S_CLR: begin
        dmem_we    = (clr_r[TBL_AW-1:DIR_AW] == '0);
        dmem_waddr = clr_r[DIR_AW-1:0];
        tmem_we    = 1'b1;
        tmem_waddr = clr_r;
        tmem_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        tmem_raddr = {in_table_slot, in_table_index};
        case (op_t'(in_op))
          OP_TRANS: dmem_raddr = in_address[31:22];
          OP_FIND:  dmem_raddr = start[19:10];
          default:  dmem_raddr = in_dir_index;
        endcase
        if (in_valid) begin
          op_nxt = op_t'(in_op);  di_nxt = in_dir_index;  ti_nxt = in_table_index;
          val_nxt = in_entry_value;  slot_nxt = in_table_slot;  va_nxt = in_address;
          pages_nxt = pages_wide[PAGES_W-1:0];
          pde_nxt = {1'b0, start[19:10]};  pte_nxt = start[9:0];
          avail_nxt = '0;  have_nxt = 1'b0;
          res_mapped_nxt = 1'b0;  res_found_nxt = 1'b0;
          res_pa_nxt = '0;  res_free_nxt = '0;
          case (op_t'(in_op))
            OP_TRANS: state_nxt = S_TDIR;
            OP_FIND: begin
              if (pages_wide == '0 || start[20]) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_FCNT;
              end
            end
            default: state_nxt = S_WR;
          endcase
        end
      end
      S_WR: begin
        dmem_we    = 1'b1;
        dmem_waddr = di_r;
        if (op_r == OP_WDIR) begin
          if (val_r == '0) begin
            cnt_new = '0;
          end else if (val_r[7]) begin
            cnt_new = CNT_FULL;
          end
          dmem_wdata = {val_r, slot_r, cnt_new};
        end else begin
          tmem_we = 1'b1;
          if (tent == '0 && val_r != '0 && dcnt < CNT_FULL) begin
            cnt_new = dcnt + 1'b1;
          end else if (tent != '0 && val_r == '0 && dcnt != '0) begin
            cnt_new = dcnt - 1'b1;
          end
          dmem_wdata = {dent, dslot, cnt_new};
        end
        state_nxt = S_RESP;
      end
      S_TDIR: begin
        tmem_raddr = {dslot, va_r[21:12]};
        if (dent == '0) begin
          state_nxt = S_RESP;
        end else if (dent[7]) begin
          res_mapped_nxt = 1'b1;
          res_pa_nxt = {dent[20:13], dent[31:22], va_r[21:0]};
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_TPTE;
        end
      end
      S_TPTE: begin
        if (tent != '0) begin
          res_mapped_nxt = 1'b1;
          res_pa_nxt = {8'd0, tent[31:12], va_r[11:0]};
        end
        state_nxt = S_RESP;
      end
      S_FCNT: begin
        fslot_nxt  = dslot;
        tmem_raddr = {dslot, pte_r};
        if (dcnt == '0 || dcnt >= CNT_FULL) begin
          pde_nxt = pde_r + 1'b1;
          pte_nxt = '0;
          dmem_raddr = pde_nxt[DIR_AW-1:0];
          if (dcnt == '0) begin
            avail_nxt = avail_r + PAGES_W'(CNT_FULL - {1'b0, pte_r});
            have_nxt  = 1'b1;
            if (!have_r) begin
              ret_nxt = {pde_r[DIR_AW-1:0], pte_r, 12'd0};
            end
          end else begin
            avail_nxt = '0;
            have_nxt  = 1'b0;
          end
          if (avail_nxt >= pages_r) begin
            res_found_nxt = 1'b1;
            res_free_nxt  = ret_nxt;
            state_nxt = S_RESP;
          end else if (pde_nxt[DIR_AW]) begin
            state_nxt = S_RESP;
          end
        end else begin
          state_nxt = S_FPTE;
        end
      end
      S_FPTE: begin
        if (tent == '0) begin
          avail_nxt = avail_r + 1'b1;
          have_nxt  = 1'b1;
          if (!have_r) begin
            ret_nxt = {pde_r[DIR_AW-1:0], pte_r, 12'd0};
          end
        end else begin
          avail_nxt = '0;
          have_nxt  = 1'b0;
        end
        pte_nxt = pte_r + 1'b1;
        if (pte_r == '1) begin
          pde_nxt = pde_r + 1'b1;
        end
        dmem_raddr = pde_nxt[DIR_AW-1:0];
        tmem_raddr = {fslot_r, pte_nxt};
        if (avail_nxt >= pages_r) begin
          res_found_nxt = 1'b1;
          res_free_nxt  = ret_nxt;
          state_nxt = S_RESP;
        end else if (pte_r == '1) begin
          state_nxt = pde_nxt[DIR_AW] ? S_RESP : S_FCNT;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_mapped_nxt = res_mapped_r;
          out_pa_nxt     = res_pa_r;
          out_found_nxt  = res_found_r;
          out_free_nxt   = res_free_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r <= op_nxt;  di_r <= di_nxt;  ti_r <= ti_nxt;  val_r <= val_nxt;
    va_r <= va_nxt;  slot_r <= slot_nxt;  fslot_r <= fslot_nxt;
    pages_r <= pages_nxt;  avail_r <= avail_nxt;  pde_r <= pde_nxt;
    pte_r <= pte_nxt;  have_r <= have_nxt;  ret_r <= ret_nxt;
    res_mapped_r <= res_mapped_nxt;  res_found_r <= res_found_nxt;
    res_pa_r <= res_pa_nxt;  res_free_r <= res_free_nxt;
    out_mapped_r <= out_mapped_nxt;  out_found_r <= out_found_nxt;
    out_pa_r <= out_pa_nxt;  out_free_r <= out_free_nxt;
  end

  `TLPW_ASSERT_NOW(a_no_accept_in_clear, state_r == S_CLR, !in_ready)
  `TLPW_ASSERT_NOW(a_one_kind_of_result, out_valid_r, !(out_mapped_r && out_found_r))
  `TLPW_ASSERT_NOW(a_dir_write_state, dmem_we, state_r == S_WR || state_r == S_CLR)
  `TLPW_ASSERT_NEXT(a_idle_after_resp, state_r == S_RESP && (!out_valid_r || out_ready),
                    state_r == S_IDLE && out_valid_r)
endmodule

[rtl/tlpw_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tlpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
